>>> src/grdt_pkg.sv
// ----------------------------------------------------------------------------
// grdt_pkg
// Shared codes, defaults and controller/datapath handshake types for the
// grid ray traversal block.
// ----------------------------------------------------------------------------
`default_nettype none

package grdt_pkg;

  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;

  localparam int FIELD_POS_W = 6;
  localparam int DIST_W      = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_WALL  = 2'd1;
  localparam logic [1:0] CELL_VDOOR = 2'd2;
  localparam logic [1:0] CELL_HDOOR = 2'd3;

  localparam logic [1:0] KIND_WALL  = 2'd0;
  localparam logic [1:0] KIND_VDOOR = 2'd1;
  localparam logic [1:0] KIND_HDOOR = 2'd2;
  localparam logic [1:0] KIND_OUT   = 2'd3;

  localparam logic SIDE_COL = 1'b0;
  localparam logic SIDE_ROW = 1'b1;

  typedef struct packed {
    logic clear_wr;   // write an empty cell at the clear pointer
    logic map_wr;     // write the incoming cell
    logic load;       // capture a cast word
    logic step;       // take one DDA step
    logic set_pend;   // capture the stop kind
    logic pend_out;   // stop kind is "left the grid"
    logic load_res;   // move the pending result into the output register
  } ctl_t;

  typedef struct packed {
    logic clear_last;
    logic start_inside;
    logic leaving;
    logic cell_stop;
    logic limit;
  } stat_t;

endpackage

`default_nettype wire

>>> src/grid_ray_door_traversal.sv
// ----------------------------------------------------------------------------
// grid_ray_door_traversal
// DDA ray walk over a 2-bit cell map with walls and doors that stop only steps along one axis.
// ----------------------------------------------------------------------------
// Usage:
//   The command channel (cmd_valid / cmd_stall) carries one word per item.
//   A word with op = 0 stores cell_kind at (row, col) and gives
//   no result; a write outside the grid is dropped. A word with op = 1 casts
//   a ray and gives exactly one result word on the result channel
//   (res_valid / res_stall).
//   After it is accepted, a cast passes a start check, then takes N steps,
//   each an add-and-compare state followed by a state for the registered
//   map read of the new cell, and then loads its result into the output
//   register, which raises res_valid. A step that leaves the grid needs no
//   read, so such a walk ends sooner. N is at most GRID_ROWS + GRID_COLS.
//   A cast starting outside the grid takes no step. The next word is taken
//   the cycle after the result is loaded. The block takes one cast at a
//   time; writes are taken every cycle while no clearing pass or cast is in progress.
//   After reset the map is cleared one cell per cycle, a pass over all
//   2**(clog2(GRID_ROWS) + clog2(GRID_COLS)) cells (4096 at 64 x 64), during
//   which cmd_stall stays high.
//   A finished result waits in the output register while res_stall is high;
//   the next word is still accepted, and a following cast waits at its end
//   until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_door_traversal #(
  parameter int GRID_ROWS = grdt_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = grdt_pkg::DEF_GRID_COLS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_stall,
  input  wire logic                             op,
  input  wire logic [grdt_pkg::FIELD_POS_W-1:0] row,
  input  wire logic [grdt_pkg::FIELD_POS_W-1:0] col,
  input  wire logic [1:0]                       cell_kind,
  input  wire logic signed [1:0]                step_col,
  input  wire logic signed [1:0]                step_row,
  input  wire logic [grdt_pkg::DIST_W-1:0]      side_x_start,
  input  wire logic [grdt_pkg::DIST_W-1:0]      side_y_start,
  input  wire logic [grdt_pkg::DIST_W-1:0]      delta_x,
  input  wire logic [grdt_pkg::DIST_W-1:0]      delta_y,
  output logic                                  res_valid,
  input  wire logic                             res_stall,
  output logic [1:0]                            hit_kind,
  output logic [grdt_pkg::FIELD_POS_W-1:0]      hit_row,
  output logic [grdt_pkg::FIELD_POS_W-1:0]      hit_col,
  output logic                                  hit_side,
  output logic [grdt_pkg::DIST_W-1:0]           side_x_end,
  output logic [grdt_pkg::DIST_W-1:0]           side_y_end
);

  grdt_pkg::ctl_t  ctl;
  grdt_pkg::stat_t st;

  grdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .op        (op),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .ctl       (ctl),
    .st        (st)
  );

  grdt_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .row          (row),
    .col          (col),
    .cell_kind    (cell_kind),
    .step_col     (step_col),
    .step_row     (step_row),
    .side_x_start (side_x_start),
    .side_y_start (side_y_start),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .hit_kind     (hit_kind),
    .hit_row      (hit_row),
    .hit_col      (hit_col),
    .hit_side     (hit_side),
    .side_x_end   (side_x_end),
    .side_y_end   (side_y_end)
  );

endmodule

`default_nettype wire

>>> src/grdt_ctrl.sv
// ----------------------------------------------------------------------------
// grdt_ctrl
// Sequencer for the grid ray traversal: map clearing pass, word intake,
// the STEP/CHECK step loop and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module grdt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire logic           op,
  output logic                cmd_stall,
  output logic                res_valid,
  input  wire logic           res_stall,
  output grdt_pkg::ctl_t      ctl,
  input  wire grdt_pkg::stat_t st
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_HOLD  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign cmd_stall = (state != ST_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (st.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          if (op == grdt_pkg::OP_WRITE) begin
            ctl.map_wr = 1'b1;
          end else begin
            ctl.load   = 1'b1;
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        if (st.start_inside) begin
          state_next = ST_STEP;
        end else begin
          ctl.set_pend = 1'b1;
          ctl.pend_out = 1'b1;
          state_next   = ST_HOLD;
        end
      end
      ST_STEP: begin
        ctl.step = 1'b1;
        if (st.leaving) begin
          ctl.set_pend = 1'b1;
          ctl.pend_out = 1'b1;
          state_next   = ST_HOLD;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.cell_stop) begin
          ctl.set_pend = 1'b1;
          state_next   = ST_HOLD;
        end else if (st.limit) begin
          ctl.set_pend = 1'b1;
          ctl.pend_out = 1'b1;
          state_next   = ST_HOLD;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_HOLD: begin
        // The output register is free or is being emptied this cycle.
        if (!res_valid || !res_stall) begin
          ctl.load_res = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_res) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/grdt_dp.sv
// ----------------------------------------------------------------------------
// grdt_dp
// Datapath of the grid ray traversal: cell map memory, ray position and
// distance registers, the saturating adders and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module grdt_dp #(
  parameter int GRID_ROWS = grdt_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = grdt_pkg::DEF_GRID_COLS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire grdt_pkg::ctl_t                ctl,
  output grdt_pkg::stat_t                    st,
  input  wire logic [grdt_pkg::FIELD_POS_W-1:0] row,
  input  wire logic [grdt_pkg::FIELD_POS_W-1:0] col,
  input  wire logic [1:0]                    cell_kind,
  input  wire logic signed [1:0]             step_col,
  input  wire logic signed [1:0]             step_row,
  input  wire logic [grdt_pkg::DIST_W-1:0]   side_x_start,
  input  wire logic [grdt_pkg::DIST_W-1:0]   side_y_start,
  input  wire logic [grdt_pkg::DIST_W-1:0]   delta_x,
  input  wire logic [grdt_pkg::DIST_W-1:0]   delta_y,
  output logic [1:0]                         hit_kind,
  output logic [grdt_pkg::FIELD_POS_W-1:0]   hit_row,
  output logic [grdt_pkg::FIELD_POS_W-1:0]   hit_col,
  output logic                               hit_side,
  output logic [grdt_pkg::DIST_W-1:0]        side_x_end,
  output logic [grdt_pkg::DIST_W-1:0]        side_y_end
);

  localparam int FW        = grdt_pkg::FIELD_POS_W;
  localparam int DW        = grdt_pkg::DIST_W;
  localparam int RW        = $clog2(GRID_ROWS);
  localparam int CW        = $clog2(GRID_COLS);
  localparam int PRW       = (RW > FW) ? RW : FW;
  localparam int PCW       = (CW > FW) ? CW : FW;
  localparam int AW        = RW + CW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int LIMIT     = GRID_ROWS + GRID_COLS;
  localparam int NW        = $clog2(LIMIT + 1);

  logic [1:0]          grid_mem [MEM_DEPTH];
  logic [1:0]          rd_data;
  logic [AW-1:0]       clear_addr;

  logic [PRW-1:0]      pos_r;
  logic [PCW-1:0]      pos_c;
  logic signed [1:0]   sc;
  logic signed [1:0]   sr;
  logic [DW-1:0]       sx;
  logic [DW-1:0]       sy;
  logic [DW-1:0]       dx;
  logic [DW-1:0]       dy;
  logic                side;
  logic [NW-1:0]       step_cnt;
  logic [1:0]          pend_kind;

  logic [PRW-1:0]      wr_r;
  logic [PCW-1:0]      wr_c;
  logic                wr_inside;
  logic                take_col;
  logic [DW:0]         sum_x;
  logic [DW:0]         sum_y;
  logic [DW-1:0]       sx_sat;
  logic [DW-1:0]       sy_sat;
  logic signed [PRW+1:0] nr;
  logic signed [PCW+1:0] nc;
  logic                next_inside;
  logic [AW-1:0]       rd_addr;
  logic [1:0]          cell_hit_kind;
  logic                cell_stop;

  assign wr_r      = PRW'(row);
  assign wr_c      = PCW'(col);
  assign wr_inside = (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS);

  // Column step when the x boundary is strictly nearer, row step otherwise.
  assign take_col = (sx < sy);
  assign sum_x    = {1'b0, sx} + {1'b0, dx};
  assign sum_y    = {1'b0, sy} + {1'b0, dy};
  assign sx_sat   = sum_x[DW] ? '1 : sum_x[DW-1:0];
  assign sy_sat   = sum_y[DW] ? '1 : sum_y[DW-1:0];

  always_comb begin
    nr = $signed({2'b00, pos_r});
    nc = $signed({2'b00, pos_c});
    if (take_col) begin
      nc = $signed({2'b00, pos_c}) + (PCW+2)'(sc);
    end else begin
      nr = $signed({2'b00, pos_r}) + (PRW+2)'(sr);
    end
  end

  assign next_inside = !nr[PRW+1] && (32'(nr) < GRID_ROWS) &&
                       !nc[PCW+1] && (32'(nc) < GRID_COLS);
  assign rd_addr     = {nr[RW-1:0], nc[CW-1:0]};

  always_comb begin
    cell_hit_kind = grdt_pkg::KIND_WALL;
    cell_stop     = 1'b0;
    unique case (rd_data)
      grdt_pkg::CELL_WALL: begin
        cell_hit_kind = grdt_pkg::KIND_WALL;
        cell_stop     = 1'b1;
      end
      grdt_pkg::CELL_VDOOR: begin
        cell_hit_kind = grdt_pkg::KIND_VDOOR;
        cell_stop     = (side == grdt_pkg::SIDE_ROW);
      end
      grdt_pkg::CELL_HDOOR: begin
        cell_hit_kind = grdt_pkg::KIND_HDOOR;
        cell_stop     = (side == grdt_pkg::SIDE_COL);
      end
      default: begin
        cell_hit_kind = grdt_pkg::KIND_WALL;
        cell_stop     = 1'b0;
      end
    endcase
  end

  assign st.cell_stop    = cell_stop;
  assign st.clear_last   = (clear_addr == '1);
  assign st.start_inside = (32'(pos_r) < GRID_ROWS) && (32'(pos_c) < GRID_COLS);
  assign st.leaving      = !next_inside;
  assign st.limit        = (step_cnt == NW'(LIMIT));

  // Map memory: one write port shared by the clearing pass and cell writes,
  // one registered read port following the next cell of the walk.
  always_ff @(posedge clk) begin
    if (ctl.clear_wr) begin
      grid_mem[clear_addr] <= grdt_pkg::CELL_EMPTY;
    end else if (ctl.map_wr && wr_inside) begin
      grid_mem[{wr_r[RW-1:0], wr_c[CW-1:0]}] <= cell_kind;
    end
    rd_data <= grid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (ctl.clear_wr) begin
      clear_addr <= clear_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos_r    <= wr_r;
      pos_c    <= wr_c;
      sc       <= step_col;
      sr       <= step_row;
      sx       <= side_x_start;
      sy       <= side_y_start;
      dx       <= delta_x;
      dy       <= delta_y;
      side     <= grdt_pkg::SIDE_COL;
      step_cnt <= '0;
    end else if (ctl.step) begin
      if (take_col) begin
        sx   <= sx_sat;
        side <= grdt_pkg::SIDE_COL;
      end else begin
        sy   <= sy_sat;
        side <= grdt_pkg::SIDE_ROW;
      end
      step_cnt <= step_cnt + NW'(1);
      if (next_inside) begin
        pos_r <= PRW'(nr);
        pos_c <= PCW'(nc);
      end
    end
    if (ctl.set_pend) begin
      pend_kind <= ctl.pend_out ? grdt_pkg::KIND_OUT : cell_hit_kind;
    end
    if (ctl.load_res) begin
      hit_kind   <= pend_kind;
      hit_row    <= pos_r[FW-1:0];
      hit_col    <= pos_c[FW-1:0];
      hit_side   <= side;
      side_x_end <= sx;
      side_y_end <= sy;
    end
  end

endmodule

`default_nettype wire

>>> verif/grid_ray_door_traversal_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_ray_door_traversal_chk
// Watches the command and result channels of the ray traversal block. It
// keeps its own copy of the cell map, walks each accepted cast through that
// map, and checks each accepted result against the oldest walk still waiting.
// ----------------------------------------------------------------------------

module grid_ray_door_traversal_chk #(
  parameter int GRID_ROWS = grdt_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = grdt_pkg::DEF_GRID_COLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  logic                             cmd_stall,
  input  logic                             op,
  input  logic [grdt_pkg::FIELD_POS_W-1:0] row,
  input  logic [grdt_pkg::FIELD_POS_W-1:0] col,
  input  logic [1:0]                       cell_kind,
  input  logic signed [1:0]                step_col,
  input  logic signed [1:0]                step_row,
  input  logic [grdt_pkg::DIST_W-1:0]      side_x_start,
  input  logic [grdt_pkg::DIST_W-1:0]      side_y_start,
  input  logic [grdt_pkg::DIST_W-1:0]      delta_x,
  input  logic [grdt_pkg::DIST_W-1:0]      delta_y,
  input  logic                             res_valid,
  input  logic                             res_stall,
  input  logic [1:0]                       hit_kind,
  input  logic [grdt_pkg::FIELD_POS_W-1:0] hit_row,
  input  logic [grdt_pkg::FIELD_POS_W-1:0] hit_col,
  input  logic                             hit_side,
  input  logic [grdt_pkg::DIST_W-1:0]      side_x_end,
  input  logic [grdt_pkg::DIST_W-1:0]      side_y_end,
  output int                               fail_count,
  output int                               pending
);
  import grdt_pkg::*;

  typedef struct packed {
    logic [1:0]             kind;
    logic [FIELD_POS_W-1:0] r;
    logic [FIELD_POS_W-1:0] c;
    logic                   side;
    logic [DIST_W-1:0]      sx;
    logic [DIST_W-1:0]      sy;
  } hit_t;

  logic [1:0] cell_map [GRID_ROWS][GRID_COLS];
  hit_t       hits_due [$];
  int         mismatches = 0;

  function automatic bit on_grid(input int r, input int c);
    return r >= 0 && r < GRID_ROWS && c >= 0 && c < GRID_COLS;
  endfunction

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? '1 : s[DIST_W-1:0];
  endfunction

  function automatic hit_t make_hit(input logic [1:0] kind, input int r, input int c,
                                    input logic side, input logic [DIST_W-1:0] sx,
                                    input logic [DIST_W-1:0] sy);
    hit_t h;
    h.kind = kind;
    h.r    = FIELD_POS_W'(r);
    h.c    = FIELD_POS_W'(c);
    h.side = side;
    h.sx   = sx;
    h.sy   = sy;
    return h;
  endfunction

  // DDA walk over the map copy; the walk gives up after rows + cols steps,
  // which only a zero step field can reach.
  function automatic hit_t trace_ray(input int r0, input int c0,
                                     input logic signed [1:0] sc,
                                     input logic signed [1:0] sr,
                                     input logic [DIST_W-1:0] sx0,
                                     input logic [DIST_W-1:0] sy0,
                                     input logic [DIST_W-1:0] dx,
                                     input logic [DIST_W-1:0] dy);
    hit_t              h;
    int                r, c, nr, nc, n;
    logic [DIST_W-1:0] sx, sy;
    logic              side;
    bit                done;
    r    = r0;
    c    = c0;
    sx   = sx0;
    sy   = sy0;
    side = SIDE_COL;
    done = 1'b0;
    if (!on_grid(r, c)) begin
      h    = make_hit(KIND_OUT, r, c, SIDE_COL, sx, sy);
      done = 1'b1;
    end
    for (n = 0; !done && n < GRID_ROWS + GRID_COLS; n++) begin
      nr = r;
      nc = c;
      if (sx < sy) begin
        sx   = sat_add(sx, dx);
        nc   = c + int'(sc);
        side = SIDE_COL;
      end else begin
        sy   = sat_add(sy, dy);
        nr   = r + int'(sr);
        side = SIDE_ROW;
      end
      if (!on_grid(nr, nc)) begin
        h    = make_hit(KIND_OUT, r, c, side, sx, sy);
        done = 1'b1;
      end else begin
        r = nr;
        c = nc;
        case (cell_map[r][c])
          CELL_WALL: begin
            h    = make_hit(KIND_WALL, r, c, side, sx, sy);
            done = 1'b1;
          end
          CELL_VDOOR: begin
            if (side == SIDE_ROW) begin
              h    = make_hit(KIND_VDOOR, r, c, side, sx, sy);
              done = 1'b1;
            end
          end
          CELL_HDOOR: begin
            if (side == SIDE_COL) begin
              h    = make_hit(KIND_HDOOR, r, c, side, sx, sy);
              done = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    if (!done) h = make_hit(KIND_OUT, r, c, side, sx, sy);
    return h;
  endfunction

  always @(posedge clk) begin
    hit_t want;
    if (rst) begin
      for (int r = 0; r < GRID_ROWS; r++)
        for (int c = 0; c < GRID_COLS; c++)
          cell_map[r][c] = CELL_EMPTY;
      hits_due.delete();
    end else begin
      // A cast accepted at this edge cannot finish at the same edge, so the
      // result side is handled first.
      if (res_valid && !res_stall) begin
        if (hits_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: kind %0d row %0d col %0d side %0d",
                     hit_kind, hit_row, hit_col, hit_side);
        end else begin
          want = hits_due.pop_front();
          if (hit_kind !== want.kind || hit_row !== want.r || hit_col !== want.c ||
              hit_side !== want.side || side_x_end !== want.sx ||
              side_y_end !== want.sy) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected kind %0d row %0d col %0d side %0d",
                       want.kind, want.r, want.c, want.side);
              $display("  expected sx %h sy %h", want.sx, want.sy);
              $display("  got kind %0d row %0d col %0d side %0d sx %h sy %h",
                       hit_kind, hit_row, hit_col, hit_side, side_x_end, side_y_end);
            end
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        if (op == OP_WRITE) begin
          if (on_grid(int'(row), int'(col))) cell_map[row][col] = cell_kind;
        end else begin
          hits_due.push_back(trace_ray(int'(row), int'(col), step_col, step_row,
                                       side_x_start, side_y_start, delta_x, delta_y));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= hits_due.size();
  end

endmodule

>>> verif/grid_ray_door_traversal_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_ray_door_traversal_tb
// Drives map writes and ray casts into the traversal block: a directed set
// of walls, doors, saturating distances and odd step codes, then a long mix
// of random writes and casts with random gaps on both channels. The checker
// beside the block predicts every result.
// ----------------------------------------------------------------------------

module grid_ray_door_traversal_tb;
  import grdt_pkg::*;

  localparam int RANDOM_WORDS = 1930;
  localparam int QUIET_TAIL   = 200;
  localparam int DRAIN_CYCLES = 300;
  localparam int DRAIN_LIMIT  = 20000;

  localparam logic signed [1:0] STEP_BACK2 = 2'b10;
  localparam logic signed [1:0] STEP_BACK  = 2'b11;
  localparam logic signed [1:0] STEP_HOLD  = 2'b00;
  localparam logic signed [1:0] STEP_FWD   = 2'b01;

  localparam logic [DIST_W-1:0] ONE_CELL = 32'h0001_0000;
  localparam logic [DIST_W-1:0] DIST_MAX = 32'hFFFF_FFFF;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cmd_valid;
  logic                   cmd_stall;
  logic                   op;
  logic [FIELD_POS_W-1:0] row, col;
  logic [1:0]             cell_kind;
  logic signed [1:0]      step_col, step_row;
  logic [DIST_W-1:0]      side_x_start, side_y_start, delta_x, delta_y;
  logic                   res_valid;
  logic                   res_stall;
  logic [1:0]             hit_kind;
  logic [FIELD_POS_W-1:0] hit_row, hit_col;
  logic                   hit_side;
  logic [DIST_W-1:0]      side_x_end, side_y_end;
  logic                   idle_on;
  int                     fail_count;
  int                     pending;

  always #5 clk = ~clk;

  grid_ray_door_traversal uut (
    .clk, .rst, .cmd_valid, .cmd_stall, .op, .row, .col, .cell_kind,
    .step_col, .step_row, .side_x_start, .side_y_start, .delta_x, .delta_y,
    .res_valid, .res_stall, .hit_kind, .hit_row, .hit_col, .hit_side,
    .side_x_end, .side_y_end
  );

  grid_ray_door_traversal_chk checker_i (
    .clk, .rst, .cmd_valid, .cmd_stall, .op, .row, .col, .cell_kind,
    .step_col, .step_row, .side_x_start, .side_y_start, .delta_x, .delta_y,
    .res_valid, .res_stall, .hit_kind, .hit_row, .hit_col, .hit_side,
    .side_x_end, .side_y_end, .fail_count, .pending
  );

  // Result side stalls in short bursts while idling is enabled.
  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      res_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic w_op, input logic [FIELD_POS_W-1:0] w_row,
                           input logic [FIELD_POS_W-1:0] w_col, input logic [1:0] w_kind,
                           input logic signed [1:0] w_sc, input logic signed [1:0] w_sr,
                           input logic [DIST_W-1:0] w_sx, input logic [DIST_W-1:0] w_sy,
                           input logic [DIST_W-1:0] w_dx, input logic [DIST_W-1:0] w_dy);
    cmd_valid    <= 1'b1;
    op           <= w_op;
    row          <= w_row;
    col          <= w_col;
    cell_kind    <= w_kind;
    step_col     <= w_sc;
    step_row     <= w_sr;
    side_x_start <= w_sx;
    side_y_start <= w_sy;
    delta_x      <= w_dx;
    delta_y      <= w_dy;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Fields that a write does not use still carry random bits.
  task automatic put_cell(input int r, input int c, input logic [1:0] kind);
    send_word(OP_WRITE, FIELD_POS_W'(r), FIELD_POS_W'(c), kind, 2'($urandom),
              2'($urandom), $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic cast_ray(input int r, input int c, input logic signed [1:0] sc,
                          input logic signed [1:0] sr, input logic [DIST_W-1:0] sx,
                          input logic [DIST_W-1:0] sy, input logic [DIST_W-1:0] dx,
                          input logic [DIST_W-1:0] dy);
    send_word(OP_CAST, FIELD_POS_W'(r), FIELD_POS_W'(c), 2'($urandom), sc, sr,
              sx, sy, dx, dy);
  endtask

  function automatic logic signed [1:0] pick_step();
    if ($urandom_range(0, 6) != 0) return $urandom_range(0, 1) ? STEP_FWD : STEP_BACK;
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic logic [DIST_W-1:0] odd_dist();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return DIST_MAX - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_write();
    int          pick;
    logic [1:0]  kind;
    pick = $urandom_range(0, 11);
    if (pick < 5)       kind = CELL_EMPTY;
    else if (pick < 8)  kind = CELL_WALL;
    else if (pick < 10) kind = CELL_VDOOR;
    else                kind = CELL_HDOOR;
    put_cell($urandom_range(0, 63), $urandom_range(0, 63), kind);
  endtask

  // Most casts look like real rays: deltas of a fraction to a few cells and
  // side distances no larger than their delta. The rest draw each distance as zero, near the maximum or any value.
  task automatic random_cast();
    logic [DIST_W-1:0] sx, sy, dx, dy;
    if ($urandom_range(0, 9) < 7) begin
      dx = $urandom_range(32'h0000_4000, 32'h0008_0000);
      dy = $urandom_range(32'h0000_4000, 32'h0008_0000);
      sx = $urandom_range(0, dx);
      sy = $urandom_range(0, dy);
    end else begin
      dx = odd_dist();
      dy = odd_dist();
      sx = odd_dist();
      sy = odd_dist();
    end
    cast_ray($urandom_range(0, 63), $urandom_range(0, 63), pick_step(), pick_step(),
             sx, sy, dx, dy);
  endtask

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int waited;
    rst          <= 1'b1;
    idle_on      <= 1'b1;
    cmd_valid    <= 1'b0;
    op           <= OP_WRITE;
    row          <= '0;
    col          <= '0;
    cell_kind    <= CELL_EMPTY;
    step_col     <= STEP_HOLD;
    step_row     <= STEP_HOLD;
    side_x_start <= '0;
    side_y_start <= '0;
    delta_x      <= '0;
    delta_y      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Leaving the grid straight from a corner, on each side.
    cast_ray(0, 0, STEP_BACK, STEP_BACK, '0, '0, ONE_CELL, ONE_CELL);
    cast_ray(63, 63, STEP_FWD, STEP_FWD, 32'd1, 32'd2, ONE_CELL, ONE_CELL);
    // A wall reached along a row, by double steps, and from inside itself.
    put_cell(10, 20, CELL_WALL);
    cast_ray(10, 0, STEP_FWD, STEP_FWD, '0, DIST_MAX, ONE_CELL, ONE_CELL);
    cast_ray(10, 24, STEP_BACK2, STEP_FWD, '0, DIST_MAX, 32'h0000_8000, '0);
    cast_ray(10, 20, STEP_HOLD, STEP_HOLD, 32'd5, 32'd6, '0, '0);
    // Zero steps and zero deltas run into the step limit.
    cast_ray(40, 40, STEP_HOLD, STEP_HOLD, '0, '0, '0, '0);
    // A vertical door is passed on a column step and stops a row step.
    put_cell(20, 5, CELL_VDOOR);
    cast_ray(20, 0, STEP_FWD, STEP_FWD, '0, DIST_MAX, ONE_CELL, '0);
    cast_ray(15, 5, STEP_FWD, STEP_FWD, DIST_MAX, '0, '0, ONE_CELL);
    // A horizontal door does the opposite.
    put_cell(30, 30, CELL_HDOOR);
    cast_ray(30, 25, STEP_FWD, STEP_FWD, '0, DIST_MAX, ONE_CELL, '0);
    cast_ray(25, 30, STEP_FWD, STEP_FWD, DIST_MAX, '0, '0, ONE_CELL);
    // Both distances saturate.
    cast_ray(5, 5, STEP_FWD, STEP_FWD, 32'hFFFF_FFF0, 32'hFFFF_FFF8, DIST_MAX, DIST_MAX);
    put_cell(0, 0, CELL_WALL);
    put_cell(63, 63, CELL_WALL);
    cast_ray(0, 10, STEP_BACK, STEP_BACK, '0, DIST_MAX, ONE_CELL, '0);
    cast_ray(50, 50, STEP_BACK2, STEP_BACK2, 32'h1000, 32'h2000, 32'h3000, 32'h3000);
    cast_ray(60, 60, STEP_FWD, STEP_FWD, 32'h8000, 32'h8000, ONE_CELL, ONE_CELL);
    cast_ray(1, 1, STEP_BACK2, STEP_BACK2, '0, '0, '0, '0);
    // Clearing the wall opens the row again.
    put_cell(10, 20, CELL_EMPTY);
    cast_ray(10, 0, STEP_FWD, STEP_FWD, '0, DIST_MAX, ONE_CELL, ONE_CELL);

    // Hold off until every outstanding cast has reported. The checker's
    // count is registered, so it lags the accepting edge.
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idle_on <= (i < RANDOM_WORDS - QUIET_TAIL) && ((i / 150) % 4 != 3);
      if ($urandom_range(0, 9) < 4) random_write();
      else random_cast();
    end
    cmd_valid <= 1'b0;
    @(posedge clk);

    for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

>>> grid_ray_door_traversal.f
src/grdt_pkg.sv
src/grdt_ctrl.sv
src/grdt_dp.sv
src/grid_ray_door_traversal.sv
verif/grid_ray_door_traversal_chk.sv
verif/grid_ray_door_traversal_tb.sv
